// File: src/rdt_pkg.sv
// package: shared constants, types and codes of the ratio deficit tracker
package rdt_pkg;

    localparam int MAX_TYPES       = 4;
    localparam int DEF_NUM_TYPES   = 4;
    localparam int DEF_COUNT_WIDTH = 24;
    localparam int TYPE_W          = 2;
    localparam int QTY_W           = 8;
    localparam int RATIO_W         = 8;
    localparam int FRAC_BITS       = 8;
    localparam int DEFICIT_W       = 40;
    localparam int TIDX_W          = 2;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    localparam logic [DEFICIT_W-1:0] TARGET_MAX = '1;

    localparam logic [RATIO_W-1:0] RATIO_RESET [MAX_TYPES] = '{8'd1, 8'd3, 8'd4, 8'd1};

    localparam logic [TIDX_W-1:0] REG_RATIO_0 = 2'd0;
    localparam logic [TIDX_W-1:0] REG_RATIO_1 = 2'd1;
    localparam logic [TIDX_W-1:0] REG_RATIO_2 = 2'd2;
    localparam logic [TIDX_W-1:0] REG_RATIO_3 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT,
        ST_MUL,
        ST_DIV,
        ST_TGT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              cnt_upd;
        logic              mul_load;
        logic              div_step;
        logic              tgt_upd;
        logic              out_load;
        logic [TIDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic valid_type;
        logic out_free;
    } t_dp_status;

endpackage

// File: src/rdt_item_if.sv
// interface: input item channel
interface rdt_item_if import rdt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] type_index;
    logic [QTY_W-1:0]  quantity;

    modport source (output valid, output type_index, output quantity, input ready);
    modport sink   (input valid, input type_index, input quantity, output ready);

endinterface

// File: src/rdt_result_if.sv
// interface: result item channel
interface rdt_result_if import rdt_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [DEFICIT_W-1:0] deficit_0;
    logic [DEFICIT_W-1:0] deficit_1;
    logic [DEFICIT_W-1:0] deficit_2;
    logic [DEFICIT_W-1:0] deficit_3;

    modport source (output valid, output deficit_0, output deficit_1, output deficit_2,
                    output deficit_3, input ready);
    modport sink   (input valid, input deficit_0, input deficit_1, input deficit_2,
                    input deficit_3, output ready);

endinterface

// File: src/ratio_deficit_tracker.sv
// ratio deficit tracker: usage notes
// Each item on i_item carries a type index and a quantity. The quantity is
// added to that type's saturating counter, then every type's target is raised
// to at least count_t * ratio_i / ratio_t in fixed point with 8 fraction bits, and one result
// item on o_result gives target minus count for every type.
// The user is to write ratios through the APB port (ratio_i at byte address
// 4*i) only while no item is in flight; the block has no check for it.
// pready is always high. One item is worked on at a time: the next item is
// accepted only once the sequencer is back in idle. An item passes through
// count update, then for each type in turn multiply, a bit-serial divide that
// produces one quotient bit per cycle, and target update, then result load;
// an item with an out-of-range type goes from count update straight to result
// load. The result is registered; after the last divide step come the target
// update, then the result load.
// A result waits in the output register while o_result.ready is low; the
// next finished result holds the sequencer until that register frees up.
// Synchronous reset clears counters, targets and output valid, and loads the
// ratios with 1, 3, 4, 1.
module ratio_deficit_tracker import rdt_pkg::*; #(
    parameter int NUM_TYPES   = DEF_NUM_TYPES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rdt_item_if.sink           i_item,
    rdt_result_if.source       o_result
);

    logic [RATIO_W-1:0]   ratio [MAX_TYPES];
    t_dp_cmd              cmd;
    t_dp_status           status;
    logic                 in_ready;
    logic                 out_valid;
    logic [DEFICIT_W-1:0] deficit [MAX_TYPES];

    rdt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ratio (ratio)
    );

    rdt_ctrl #(
        .NUM_TYPES   (NUM_TYPES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rdt_datapath #(
        .NUM_TYPES   (NUM_TYPES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_type_index (i_item.type_index),
        .i_quantity   (i_item.quantity),
        .i_ratio      (ratio),
        .i_out_ready  (o_result.ready),
        .o_out_valid  (out_valid),
        .o_deficit    (deficit)
    );

    assign i_item.ready       = in_ready;
    assign o_result.valid     = out_valid;
    assign o_result.deficit_0 = deficit[0];
    assign o_result.deficit_1 = deficit[1];
    assign o_result.deficit_2 = deficit[2];
    assign o_result.deficit_3 = deficit[3];

endmodule

// File: src/rdt_cfg_regs.sv
// module: apb ratio register bank
module rdt_cfg_regs import rdt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [RATIO_W-1:0] o_ratio [MAX_TYPES]
);

    logic [RATIO_W-1:0] r_ratio [MAX_TYPES];
    logic [TIDX_W-1:0]  reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RATIO_0: r_ratio[0] <= pwdata[RATIO_W-1:0];
                REG_RATIO_1: r_ratio[1] <= pwdata[RATIO_W-1:0];
                REG_RATIO_2: r_ratio[2] <= pwdata[RATIO_W-1:0];
                REG_RATIO_3: r_ratio[3] <= pwdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RATIO_0: prdata = PDATA_W'(r_ratio[0]);
            REG_RATIO_1: prdata = PDATA_W'(r_ratio[1]);
            REG_RATIO_2: prdata = PDATA_W'(r_ratio[2]);
            REG_RATIO_3: prdata = PDATA_W'(r_ratio[3]);
            default:     prdata = '0;
        endcase
    end

    assign o_ratio = r_ratio;

endmodule

// File: src/rdt_ctrl.sv
// module: sequencer for count update, per-type divide and result load
module rdt_ctrl import rdt_pkg::*; #(
    parameter int NUM_TYPES   = DEF_NUM_TYPES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int IDX_W  = $clog2(NUM_TYPES);
    localparam int DIV_W  = COUNT_WIDTH + RATIO_W + FRAC_BITS;
    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_TYPES - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_step <= '0;
        end else begin
            if (r_state == ST_CNT) begin
                r_idx <= '0;
            end else if (r_state == ST_TGT) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == ST_MUL) begin
                r_step <= '0;
            end else if (r_state == ST_DIV) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CNT;
            end
            ST_CNT: begin
                n_state = i_status.valid_type ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == STEP_LAST) n_state = ST_TGT;
            end
            ST_TGT: begin
                n_state = (r_idx == IDX_LAST) ? ST_OUT : ST_MUL;
            end
            ST_OUT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.idx      = TIDX_W'(r_idx);
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_CNT:  o_cmd.cnt_upd  = i_status.valid_type;
            ST_MUL:  o_cmd.mul_load = 1'b1;
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_TGT:  o_cmd.tgt_upd  = 1'b1;
            ST_OUT:  o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// File: src/rdt_datapath.sv
// module: counters, targets, shared multiplier and radix-2 divider, result register
module rdt_datapath import rdt_pkg::*; #(
    parameter int NUM_TYPES   = DEF_NUM_TYPES,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic [TYPE_W-1:0]    i_type_index,
    input  logic [QTY_W-1:0]     i_quantity,
    input  logic [RATIO_W-1:0]   i_ratio [MAX_TYPES],
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [DEFICIT_W-1:0] o_deficit [MAX_TYPES]
);

    localparam int IDX_W  = $clog2(NUM_TYPES);
    localparam int PROD_W = COUNT_WIDTH + RATIO_W;
    localparam int DIV_W  = PROD_W + FRAC_BITS;
    localparam int QW     = (DIV_W > DEFICIT_W) ? DIV_W : DEFICIT_W;

    logic [TYPE_W-1:0]      r_type;
    logic [QTY_W-1:0]       r_qty;
    logic [COUNT_WIDTH-1:0] r_cnt [NUM_TYPES];
    logic [DEFICIT_W-1:0]   r_tgt [NUM_TYPES];
    logic [DIV_W-1:0]       r_dvd;
    logic [RATIO_W-1:0]     r_rem;
    logic                   r_out_valid;
    logic [DEFICIT_W-1:0]   r_def [MAX_TYPES];

    logic [IDX_W-1:0]       type_sel;
    logic [IDX_W-1:0]       idx_sel;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [RATIO_W-1:0]     divisor;
    logic [PROD_W-1:0]      prod;
    logic [RATIO_W:0]       rem_sh;
    logic [RATIO_W:0]       rem_diff;
    logic                   q_bit;
    logic [RATIO_W-1:0]     n_rem;
    logic [QW-1:0]          q_ext;
    logic [DEFICIT_W-1:0]   cand;
    logic [DEFICIT_W-1:0]   n_def [MAX_TYPES];

    assign type_sel = r_type[IDX_W-1:0];
    assign idx_sel  = i_cmd.idx[IDX_W-1:0];

    assign o_status.valid_type = ({1'b0, r_type} < (TYPE_W+1)'(NUM_TYPES));
    assign o_status.out_free   = ~r_out_valid | i_out_ready;

    // saturating counter add
    assign cnt_sum = {1'b0, r_cnt[type_sel]} + (COUNT_WIDTH+1)'(r_qty);
    assign n_cnt   = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];

    // zero ratio divides as one
    assign divisor = (i_ratio[r_type] == '0) ? RATIO_W'(1) : i_ratio[r_type];

    assign prod = PROD_W'(r_cnt[type_sel]) * PROD_W'(i_ratio[i_cmd.idx]);

    // restoring divide, one quotient bit per step
    assign rem_sh   = {r_rem, r_dvd[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, divisor};
    assign q_bit    = (rem_sh >= {1'b0, divisor});
    assign n_rem    = q_bit ? rem_diff[RATIO_W-1:0] : rem_sh[RATIO_W-1:0];

    assign q_ext = QW'(r_dvd);
    assign cand  = (q_ext > QW'(TARGET_MAX)) ? TARGET_MAX : q_ext[DEFICIT_W-1:0];

    for (genvar k = 0; k < MAX_TYPES; k++) begin : g_def
        if (k < NUM_TYPES) begin : g_used
            logic [DEFICIT_W-1:0] cf;
            assign cf       = DEFICIT_W'({r_cnt[k], {FRAC_BITS{1'b0}}});
            assign n_def[k] = (r_tgt[k] > cf) ? (r_tgt[k] - cf) : '0;
        end else begin : g_unused
            assign n_def[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_type_index;
            r_qty  <= i_quantity;
        end
        if (i_cmd.mul_load) begin
            r_dvd <= {prod, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DIV_W-2:0], q_bit};
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_def <= n_def;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_cnt[k] <= '0;
                r_tgt[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_upd) begin
                r_cnt[type_sel] <= n_cnt;
            end
            if (i_cmd.tgt_upd && (cand > r_tgt[idx_sel])) begin
                r_tgt[idx_sel] <= cand;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_deficit   = r_def;

endmodule

// File: test/rdt_checker.sv
// ratio deficit tracker checker: tracks ratio writes and items, predicts deficits, compares results
`timescale 1ns / 1ps
module rdt_checker import rdt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    rdt_item_if                i_item,
    rdt_result_if              i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int          NUM_TYPES   = DEF_NUM_TYPES;
    localparam int          MAX_REPORTS = 10;
    localparam logic [63:0] COUNT_MAX   = (64'd1 << DEF_COUNT_WIDTH) - 64'd1;

    typedef logic [MAX_TYPES-1:0][DEFICIT_W-1:0] t_deficits;

    logic [RATIO_W-1:0]   ratio_copy [MAX_TYPES];
    logic [63:0]          type_totals [MAX_TYPES];
    logic [DEFICIT_W-1:0] type_goals [MAX_TYPES];
    t_deficits            expected_deficits [$];
    int                   mismatch_total;

    function automatic t_deficits tally_item(input logic [TYPE_W-1:0] kind,
                                             input logic [QTY_W-1:0] qty);
        logic [63:0] sum;
        logic [63:0] divisor;
        logic [63:0] base;
        logic [63:0] cand;
        logic [63:0] scaled;
        t_deficits   deficits;
        int          i;
        if (int'(kind) < NUM_TYPES) begin
            sum = type_totals[kind] + 64'(qty);
            if (sum > COUNT_MAX) begin
                sum = COUNT_MAX;
            end
            type_totals[kind] = sum;
            divisor = (ratio_copy[kind] == '0) ? 64'd1 : 64'(ratio_copy[kind]);
            base = sum << FRAC_BITS;
            for (i = 0; i < NUM_TYPES; i++) begin
                cand = (base * 64'(ratio_copy[i])) / divisor;
                if (cand > 64'(TARGET_MAX)) begin
                    cand = 64'(TARGET_MAX);
                end
                if (cand[DEFICIT_W-1:0] > type_goals[i]) begin
                    type_goals[i] = cand[DEFICIT_W-1:0];
                end
            end
        end
        deficits = '0;
        for (i = 0; i < NUM_TYPES; i++) begin
            scaled = type_totals[i] << FRAC_BITS;
            if (64'(type_goals[i]) > scaled) begin
                deficits[i] = DEFICIT_W'(64'(type_goals[i]) - scaled);
            end
        end
        return deficits;
    endfunction

    task automatic note_mismatch(input string what, input logic [DEFICIT_W-1:0] want,
                                 input logic [DEFICIT_W-1:0] got);
        mismatch_total++;
        if (mismatch_total <= MAX_REPORTS) begin
            $display("%0t: %s expected %h got %h", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_deficits want;
        t_deficits got;
        int        k;
        if (!i_rst_n) begin
            for (k = 0; k < MAX_TYPES; k++) begin
                ratio_copy[k]  = RATIO_RESET[k];
                type_totals[k] = '0;
                type_goals[k]  = '0;
            end
            expected_deficits.delete();
            mismatch_total = 0;
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (int'(i_paddr >> 2) < MAX_TYPES) begin
                    ratio_copy[int'(i_paddr >> 2)] = i_pwdata[RATIO_W-1:0];
                end
            end
            // results first so a same-edge item cannot be matched against itself
            if (i_result.valid && i_result.ready) begin
                got = {i_result.deficit_3, i_result.deficit_2,
                       i_result.deficit_1, i_result.deficit_0};
                if (expected_deficits.size() == 0) begin
                    for (k = 0; k < MAX_TYPES; k++) begin
                        note_mismatch($sformatf("unrequested result deficit_%0d", k),
                                      '0, got[k]);
                    end
                end else begin
                    want = expected_deficits.pop_front();
                    for (k = 0; k < MAX_TYPES; k++) begin
                        if (got[k] !== want[k]) begin
                            note_mismatch($sformatf("deficit_%0d", k), want[k], got[k]);
                        end
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_deficits.push_back(tally_item(i_item.type_index, i_item.quantity));
            end
            o_pending    <= expected_deficits.size();
            o_fail_count <= mismatch_total;
        end
    end

endmodule

// File: test/testbench.sv
// ratio deficit tracker testbench top: clock, reset, ratio writes, item stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import rdt_pkg::*;

    localparam int ITEM_CYCLES     = 3 + DEF_NUM_TYPES * (DEF_COUNT_WIDTH + 18);
    localparam int MAX_GAP         = 16;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 8 * (ITEM_CYCLES + 2 * MAX_GAP + 16);
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 62;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               no_idle = 1'b0;
    int                 fail_count;
    int                 pending_count;
    int                 idle_cycles = 0;

    rdt_item_if   item_ch ();
    rdt_result_if result_ch ();

    ratio_deficit_tracker uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    rdt_checker deficit_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: after each accepted result, optionally stall once the next result shows up
    initial begin
        int gap;
        result_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        result_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (result_ch.valid && result_ch.ready) begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    result_ch.ready <= 1'b0;
                    do @(posedge i_clk); while (!result_ch.valid);
                    repeat (gap - 1) @(posedge i_clk);
                    result_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic write_ratio(input logic [TIDX_W-1:0] reg_idx,
                               input logic [RATIO_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= {(PDATA_W - RATIO_W)'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_ratios(input logic [RATIO_W-1:0] r0, input logic [RATIO_W-1:0] r1,
                                input logic [RATIO_W-1:0] r2, input logic [RATIO_W-1:0] r3);
        write_ratio(REG_RATIO_0, r0);
        write_ratio(REG_RATIO_1, r1);
        write_ratio(REG_RATIO_2, r2);
        write_ratio(REG_RATIO_3, r3);
    endtask

    task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [QTY_W-1:0] qty);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.type_index <= kind;
        item_ch.quantity   <= qty;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
    endtask

    task automatic drain(input int extra_cycles);
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    function automatic logic [RATIO_W-1:0] pick_ratio();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return RATIO_W'(1);
            default: return RATIO_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [QTY_W-1:0] pick_quantity();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return QTY_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int phase;
        int n;
        item_ch.valid      = 1'b0;
        item_ch.type_index = '0;
        item_ch.quantity   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset ratios, field extremes and alternating bits
        send_item(2'd0, 8'd0);
        send_item(2'd1, 8'd255);
        send_item(2'd2, 8'hAA);
        send_item(2'd3, 8'h55);
        send_item(2'd0, 8'd255);
        send_item(2'd3, 8'd0);
        drain(SETTLE_CYCLES);

        write_ratios(8'd255, 8'd1, 8'd255, 8'd1);
        send_item(2'd1, 8'd255);
        send_item(2'd0, 8'd1);
        send_item(2'd2, 8'd255);
        send_item(2'd3, 8'd128);
        drain(SETTLE_CYCLES);

        // zero ratios: divisor taken as one, multiplier stays zero
        write_ratios(8'd0, 8'd0, 8'd0, 8'd0);
        send_item(2'd0, 8'd17);
        send_item(2'd1, 8'd200);
        send_item(2'd2, 8'd255);
        send_item(2'd3, 8'd1);
        drain(SETTLE_CYCLES);

        write_ratios(8'd0, 8'd255, 8'd1, 8'd128);
        send_item(2'd0, 8'd5);
        send_item(2'd1, 8'd77);
        send_item(2'd3, 8'd255);
        send_item(2'd2, 8'd0);
        drain(SETTLE_CYCLES);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_ratios(pick_ratio(), pick_ratio(), pick_ratio(), pick_ratio());
            no_idle = (phase % 3 == 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
                    drain(0);
                end
                send_item(TYPE_W'($urandom_range(0, 3)), pick_quantity());
            end
            drain(SETTLE_CYCLES);
        end
        no_idle = 1'b0;

        drain(ITEM_CYCLES);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
